// ===== src/nrfe_pkg.sv =====
package nrfe_pkg;

    localparam int HOUR_W = 7;
    localparam int MIN_W  = 7;
    localparam int LAT_W  = 32;
    localparam int LON_W  = 36;
    localparam int DATE_W = 24;

    typedef struct packed {
        logic              has_fix;
        logic [HOUR_W-1:0] utc_hour;
        logic [MIN_W-1:0]  utc_minute;
        logic [LAT_W-1:0]  latitude_bcd;
        logic [LON_W-1:0]  longitude_bcd;
        logic [DATE_W-1:0] date_bcd;
    } t_rmc_res;

endpackage

// ===== src/nrfe_in_if.sv =====
interface nrfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/nrfe_out_if.sv =====
interface nrfe_out_if;
    import nrfe_pkg::*;

    logic              valid;
    logic              ready;
    logic              has_fix;
    logic [HOUR_W-1:0] utc_hour;
    logic [MIN_W-1:0]  utc_minute;
    logic [LAT_W-1:0]  latitude_bcd;
    logic [LON_W-1:0]  longitude_bcd;
    logic [DATE_W-1:0] date_bcd;

    modport source (
        output valid, output has_fix, output utc_hour, output utc_minute,
        output latitude_bcd, output longitude_bcd, output date_bcd,
        input ready
    );
    modport sink (
        input valid, input has_fix, input utc_hour, input utc_minute,
        input latitude_bcd, input longitude_bcd, input date_bcd,
        output ready
    );
endinterface

// ===== src/nrfe_parser.sv =====
module nrfe_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    output logic              o_emit,
    output nrfe_pkg::t_rmc_res o_res
);
    import nrfe_pkg::*;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_PERIOD = 8'd46;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_NINE   = 8'd57;
    localparam logic [7:0] CH_ACTIVE = 8'd65;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam int LAT_DIGITS  = LAT_W / 4;
    localparam int LON_DIGITS  = LON_W / 4;
    localparam int DATE_DIGITS = DATE_W / 4;

    localparam logic [3:0] FLD_TIME   = 4'd0;
    localparam logic [3:0] FLD_STATUS = 4'd1;
    localparam logic [3:0] FLD_LAT    = 4'd2;
    localparam logic [3:0] FLD_LON    = 4'd4;
    localparam logic [3:0] FLD_DATE   = 4'd8;
    localparam logic [3:0] CNT_MAX    = 4'd15;

    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'd36;
            3'd1:    c = 8'd71;
            3'd2:    c = 8'd80;
            3'd3:    c = 8'd82;
            3'd4:    c = 8'd77;
            3'd5:    c = 8'd67;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] times_ten(input logic [3:0] d);
        return 7'({d, 3'b000}) + 7'({d, 1'b0});
    endfunction

    logic [2:0]        r_pm,   n_pm;
    logic              r_in,   n_in;
    logic [3:0]        r_comma, n_comma;
    logic [3:0]        r_char, n_char;
    logic              r_fix,  n_fix;
    logic [HOUR_W-1:0] r_hour, n_hour;
    logic [MIN_W-1:0]  r_min,  n_min;
    logic [LAT_W-1:0]  r_lat,  n_lat;
    logic [LON_W-1:0]  r_lon,  n_lon;
    logic [DATE_W-1:0] r_date, n_date;

    logic [3:0] digit;
    logic       emit;

    // non-digits count as zero
    assign digit = (i_byte >= CH_ZERO && i_byte <= CH_NINE) ? 4'(i_byte - CH_ZERO) : 4'd0;

    always_comb begin
        n_pm    = r_pm;
        n_in    = r_in;
        n_comma = r_comma;
        n_char  = r_char;
        n_fix   = r_fix;
        n_hour  = r_hour;
        n_min   = r_min;
        n_lat   = r_lat;
        n_lon   = r_lon;
        n_date  = r_date;
        emit    = 1'b0;

        if (i_byte == CH_DOLLAR) begin
            n_in = 1'b0;
            n_pm = 3'd1;
        end else if (r_pm == PREFIX_LEN) begin
            // separator after the prefix is skipped
            n_pm = 3'd0;
            if (i_byte == CH_CR) begin
                emit = 1'b1;
            end else begin
                n_in = 1'b1;
            end
        end else if (r_in) begin
            if (i_byte == CH_CR) begin
                n_in = 1'b0;
                emit = 1'b1;
            end else if (i_byte == CH_COMMA) begin
                if (r_comma != CNT_MAX) begin
                    n_comma = r_comma + 4'd1;
                end
                n_char = 4'd0;
            end else if (i_byte != CH_PERIOD) begin
                unique case (r_comma)
                    FLD_TIME: begin
                        unique case (r_char)
                            4'd0:    n_hour = times_ten(digit);
                            4'd1:    n_hour = r_hour + 7'(digit);
                            4'd2:    n_min  = times_ten(digit);
                            4'd3:    n_min  = r_min + 7'(digit);
                            default: ;
                        endcase
                    end
                    FLD_STATUS: begin
                        if (r_char == 4'd0) begin
                            n_fix = (i_byte == CH_ACTIVE);
                        end
                    end
                    FLD_LAT: begin
                        for (int i = 0; i < LAT_DIGITS; i++) begin
                            if (r_char == 4'(i)) begin
                                n_lat[4*(LAT_DIGITS-1-i) +: 4] =
                                    r_lat[4*(LAT_DIGITS-1-i) +: 4] | digit;
                            end
                        end
                    end
                    FLD_LON: begin
                        for (int i = 0; i < LON_DIGITS; i++) begin
                            if (r_char == 4'(i)) begin
                                n_lon[4*(LON_DIGITS-1-i) +: 4] =
                                    r_lon[4*(LON_DIGITS-1-i) +: 4] | digit;
                            end
                        end
                    end
                    FLD_DATE: begin
                        for (int i = 0; i < DATE_DIGITS; i++) begin
                            if (r_char == 4'(i)) begin
                                n_date[4*(DATE_DIGITS-1-i) +: 4] =
                                    r_date[4*(DATE_DIGITS-1-i) +: 4] | digit;
                            end
                        end
                    end
                    default: ;
                endcase
                if (r_char != CNT_MAX) begin
                    n_char = r_char + 4'd1;
                end
            end
        end else begin
            if (i_byte == prefix_char(r_pm)) begin
                n_pm = r_pm + 3'd1;
            end else begin
                n_pm = 3'd0;
            end
            // prefix complete: start a fresh set of fields
            if (n_pm == PREFIX_LEN) begin
                n_comma = 4'd0;
                n_char  = 4'd0;
                n_fix   = 1'b0;
                n_hour  = '0;
                n_min   = '0;
                n_lat   = '0;
                n_lon   = '0;
                n_date  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm    <= 3'd0;
            r_in    <= 1'b0;
            r_comma <= 4'd0;
            r_char  <= 4'd0;
        end else if (i_take) begin
            r_pm    <= n_pm;
            r_in    <= n_in;
            r_comma <= n_comma;
            r_char  <= n_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_fix  <= n_fix;
            r_hour <= n_hour;
            r_min  <= n_min;
            r_lat  <= n_lat;
            r_lon  <= n_lon;
            r_date <= n_date;
        end
    end

    assign o_emit = emit;

    always_comb begin
        o_res.has_fix       = r_fix;
        o_res.utc_hour      = r_hour;
        o_res.utc_minute    = r_min;
        o_res.latitude_bcd  = r_lat;
        o_res.longitude_bcd = r_lon;
        o_res.date_bcd      = r_date;
    end

endmodule

// ===== src/nmea_rmc_field_extractor_unit.sv =====
// a result beat is registered and appears in the cycle after the carriage return byte is taken
// one byte per cycle while no held result stalls the input; the parser state updates once per byte taken
// a held result blocks input only while the output is not ready; input is taken while it is being drained
// reset: synchronous active low, clears the prefix match, sentence and comma/char
// counters and the output valid; field values are cleared at each sentence start
module nmea_rmc_field_extractor_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    nrfe_in_if.sink    i_in,
    nrfe_out_if.source o_out
);
    import nrfe_pkg::*;

    logic     take;
    logic     emit;
    t_rmc_res res;
    logic     r_out_valid;
    t_rmc_res r_out;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    nrfe_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_in.rx_byte),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.has_fix       = r_out.has_fix;
    assign o_out.utc_hour      = r_out.utc_hour;
    assign o_out.utc_minute    = r_out.utc_minute;
    assign o_out.latitude_bcd  = r_out.latitude_bcd;
    assign o_out.longitude_bcd = r_out.longitude_bcd;
    assign o_out.date_bcd      = r_out.date_bcd;

endmodule
